FILE: rtl/cpu32_instruction_step_macros.svh
// assertion macros shared by the checker
`ifndef CPU32_INSTRUCTION_STEP_MACROS_SVH
`define CPU32_INSTRUCTION_STEP_MACROS_SVH

// same-cycle implication
`define C32IS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define C32IS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/c32is_pkg.sv
// ----------------------------------------------------------------------------
// c32is_pkg
// shared constants, opcodes and types of the 32-bit instruction step core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package c32is_pkg;

	localparam int XLEN          = 32;
	localparam int PC_W          = 24;
	localparam int NREG          = 16;
	localparam int RIDX_W        = 4;
	localparam int MEM_DEPTH_DEF = 65536;

	// opcodes, bits 31:28
	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_ALU = 4'd1;
	localparam logic [3:0] OP_CMP = 4'd2;
	localparam logic [3:0] OP_JMP = 4'd3;
	localparam logic [3:0] OP_LDD = 4'd4;
	localparam logic [3:0] OP_LDR = 4'd5;
	localparam logic [3:0] OP_LDI = 4'd6;
	localparam logic [3:0] OP_STD = 4'd7;
	localparam logic [3:0] OP_STR = 4'd8;
	localparam logic [3:0] OP_MOV = 4'd9;
	localparam logic [3:0] OP_OUT = 4'd10;

	// alu functions, bits 15:12
	localparam logic [3:0] ALU_ADD  = 4'd0;
	localparam logic [3:0] ALU_SUB  = 4'd1;
	localparam logic [3:0] ALU_MUL  = 4'd2;
	localparam logic [3:0] ALU_NEG  = 4'd3;
	localparam logic [3:0] ALU_AND  = 4'd4;
	localparam logic [3:0] ALU_OR   = 4'd5;
	localparam logic [3:0] ALU_NOT  = 4'd6;
	localparam logic [3:0] ALU_NAND = 4'd7;
	localparam logic [3:0] ALU_XOR  = 4'd8;
	localparam logic [3:0] ALU_XNOR = 4'd9;
	localparam logic [3:0] ALU_SHL  = 4'd10;
	localparam logic [3:0] ALU_SHR  = 4'd11;
	localparam logic [3:0] ALU_SRA  = 4'd12;
	localparam logic [3:0] ALU_ROL  = 4'd13;

	// compare functions
	localparam logic [3:0] CMP_GT = 4'd0;
	localparam logic [3:0] CMP_EQ = 4'd1;
	localparam logic [3:0] CMP_LT = 4'd2;
	localparam logic [3:0] CMP_GE = 4'd3;
	localparam logic [3:0] CMP_LE = 4'd4;

	// jump conditions
	localparam logic [3:0] JC_ALWAYS = 4'd0;
	localparam logic [3:0] JC_CARRY  = 4'd1;
	localparam logic [3:0] JC_CMP    = 4'd2;
	localparam logic [3:0] JC_NCMP   = 4'd3;

	typedef struct packed {
		logic [XLEN-1:0] value;
		logic            carry;
		logic            cmp;
	} alu_res_t;

endpackage

FILE: rtl/c32is_ram.sv
// ----------------------------------------------------------------------------
// c32is_ram
// generic single-clock ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c32is_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/c32is_alu.sv
// ----------------------------------------------------------------------------
// c32is_alu
// arithmetic, logic, shift and unsigned compare unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c32is_alu import c32is_pkg::*; (
	input  logic [3:0]      fn,
	input  logic [XLEN-1:0] a,
	input  logic [XLEN-1:0] b,
	input  logic [3:0]      n,
	output alu_res_t        res
);

	logic [XLEN:0]     sum;
	logic [2*XLEN-1:0] prod;
	logic [2*XLEN-1:0] rot;

	always_comb begin
		sum  = {1'b0, a} + {1'b0, b};
		prod = {{XLEN{1'b0}}, a} * {{XLEN{1'b0}}, b};
		rot  = {a, a} << n;
		res.carry = sum[XLEN];
		unique case (fn)
			ALU_ADD:  res.value = sum[XLEN-1:0];
			ALU_SUB:  res.value = a - b;
			ALU_MUL:  res.value = prod[XLEN-1:0];
			ALU_NEG:  res.value = '0 - a;
			ALU_AND:  res.value = a & b;
			ALU_OR:   res.value = a | b;
			ALU_NOT:  res.value = ~a;
			ALU_NAND: res.value = ~(a & b);
			ALU_XOR:  res.value = a ^ b;
			ALU_XNOR: res.value = ~(a ^ b);
			ALU_SHL:  res.value = a << n;
			ALU_SHR:  res.value = a >> n;
			ALU_SRA:  res.value = $unsigned($signed(a) >>> n);
			ALU_ROL:  res.value = rot[2*XLEN-1:XLEN];
			default:  res.value = '0;
		endcase
		unique case (fn)
			CMP_GT:  res.cmp = a > b;
			CMP_EQ:  res.cmp = a == b;
			CMP_LT:  res.cmp = a < b;
			CMP_GE:  res.cmp = a >= b;
			CMP_LE:  res.cmp = a <= b;
			default: res.cmp = 1'b0;
		endcase
	end

endmodule

FILE: rtl/cpu32_instruction_step.sv
// ----------------------------------------------------------------------------
// cpu32_instruction_step
// 32-bit, 16-register core with one word memory, one beat per step
// ----------------------------------------------------------------------------
// sequence: a memory write beat or a beat while halted goes from accept straight
//   to done; an execute beat passes fetch and execute, an indirect load also load
// throughput: one beat at a time; in_stall is high until the core is back in idle,
//   which it reaches from done only when the output register is free
// reset: clears pc, flags, halt, ports and register valid bits; the word
//   memory keeps its contents and needs no clearing pass
`timescale 1ns / 1ps

module cpu32_instruction_step import c32is_pkg::*; #(
	parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            action,
	input  logic [15:0]     address,
	input  logic [XLEN-1:0] data,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [PC_W-1:0] pc,
	output logic            halted,
	output logic            port_strobe,
	output logic [XLEN-1:0] port_data_a,
	output logic [XLEN-1:0] port_data_b,
	output logic [2:0]      port_select,
	output logic            carry_flag,
	output logic            compare_flag
);

	localparam int          AW      = $clog2(MEM_DEPTH);
	localparam logic [PC_W:0] MEM_LIM = (PC_W+1)'(MEM_DEPTH);

	// sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;

	// architectural state
	logic [PC_W-1:0] pc_q;
	logic            halt_q, carry_q, cmp_q, strobe_q;
	logic [XLEN-1:0] porta_q, portb_q;
	logic [2:0]      psel_q;
	logic [NREG-1:0] rf_valid_q;

	// per-step working registers
	logic [XLEN-1:0] instr_q;
	logic            rd_oob_q;
	logic            va_q, vb_q;

	// output beat
	logic            out_valid_q;
	logic [PC_W-1:0] pc_out_q;
	logic            halt_out_q, strobe_out_q, carry_out_q, cmp_out_q;
	logic [XLEN-1:0] porta_out_q, portb_out_q;
	logic [2:0]      psel_out_q;

	// memory ports
	logic            mem_we, mem_re;
	logic [PC_W-1:0] mem_wa24, mem_ra24;
	logic [XLEN-1:0] mem_wdata, mem_rdata, mem_word;

	// register file ports, two copies for two reads
	logic              rf_we;
	logic [RIDX_W-1:0] rf_waddr, rf_ra, rf_rb;
	logic [XLEN-1:0]   rf_wdata, rfa_rdata, rfb_rdata;
	logic              rf_re;

	logic            in_acc, out_free;
	logic [XLEN-1:0] fetch_word;
	logic [3:0]      opc, f_a, f_b, f_d, f_fn;
	logic [PC_W-1:0] imm;
	logic [XLEN-1:0] va, vb;
	logic            take, stop;
	alu_res_t        alu_res;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// memory read data, zero for addresses past the end
	assign mem_word   = rd_oob_q ? '0 : mem_rdata;
	assign fetch_word = mem_word;

	// instruction fields
	assign opc  = instr_q[31:28];
	assign f_a  = instr_q[27:24];
	assign f_b  = instr_q[23:20];
	assign f_d  = instr_q[19:16];
	assign f_fn = instr_q[15:12];
	assign imm  = instr_q[PC_W-1:0];

	// unwritten registers read as zero
	assign va = va_q ? rfa_rdata : '0;
	assign vb = vb_q ? rfb_rdata : '0;

	c32is_alu u_alu (
		.fn  (f_fn),
		.a   (va),
		.b   (vb),
		.n   (f_b),
		.res (alu_res)
	);

	// jump condition decode
	always_comb begin
		take = 1'b0;
		stop = 1'b0;
		unique case (f_a)
			JC_ALWAYS: take = 1'b1;
			JC_CARRY:  take = carry_q;
			JC_CMP:    take = cmp_q;
			JC_NCMP:   take = !cmp_q;
			default:   stop = 1'b1;
		endcase
	end

	// memory port steering
	always_comb begin
		mem_re    = 1'b0;
		mem_ra24  = pc_q;
		mem_we    = 1'b0;
		mem_wa24  = {{(PC_W-16){1'b0}}, address};
		mem_wdata = data;
		unique case (state_q)
			ST_IDLE: begin
				mem_we   = in_acc && !action;
				mem_re   = in_acc && action && !halt_q;
				mem_ra24 = pc_q;
			end
			ST_FETCH: begin
				// direct load operand read, ahead of the decode
				mem_re   = 1'b1;
				mem_ra24 = fetch_word[PC_W-1:0];
			end
			ST_EXEC: begin
				mem_re    = (opc == OP_LDR);
				mem_ra24  = vb[PC_W-1:0];
				mem_we    = (opc == OP_STD) || (opc == OP_STR);
				mem_wa24  = (opc == OP_STD) ? imm : vb[PC_W-1:0];
				mem_wdata = va;
			end
			default: ;
		endcase
	end

	c32is_ram #(.WIDTH(XLEN), .DEPTH(MEM_DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we && ({1'b0, mem_wa24} < MEM_LIM)),
		.waddr (mem_wa24[AW-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_ra24[AW-1:0]),
		.rdata (mem_rdata)
	);

	// register file reads are issued while the fetched word is on the bus
	assign rf_re = (state_q == ST_FETCH);
	assign rf_ra = fetch_word[27:24];
	assign rf_rb = fetch_word[23:20];

	// register file writeback
	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = f_d;
		rf_wdata = alu_res.value;
		if (state_q == ST_EXEC) begin
			unique case (opc)
				OP_ALU: begin
					rf_we = 1'b1;
				end
				OP_LDD: begin
					rf_we    = 1'b1;
					rf_waddr = f_a;
					rf_wdata = mem_word;
				end
				OP_LDI: begin
					rf_we    = 1'b1;
					rf_waddr = f_a;
					rf_wdata = {{(XLEN-PC_W){1'b0}}, imm};
				end
				OP_MOV: begin
					rf_we    = 1'b1;
					rf_wdata = va;
				end
				default: ;
			endcase
		end else if (state_q == ST_LOAD) begin
			rf_we    = 1'b1;
			rf_wdata = mem_word;
		end
	end

	c32is_ram #(.WIDTH(XLEN), .DEPTH(NREG)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (rf_re),
		.raddr (rf_ra),
		.rdata (rfa_rdata)
	);

	c32is_ram #(.WIDTH(XLEN), .DEPTH(NREG)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (rf_re),
		.raddr (rf_rb),
		.rdata (rfb_rdata)
	);

	// payload registers of the step
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_oob_q <= !({1'b0, mem_ra24} < MEM_LIM);
		end
		if (state_q == ST_FETCH) begin
			instr_q <= fetch_word;
			va_q    <= rf_valid_q[rf_ra];
			vb_q    <= rf_valid_q[rf_rb];
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pc_q       <= '0;
			halt_q     <= 1'b0;
			carry_q    <= 1'b0;
			cmp_q      <= 1'b0;
			strobe_q   <= 1'b0;
			porta_q    <= '0;
			portb_q    <= '0;
			psel_q     <= '0;
			rf_valid_q <= '0;
		end else begin
			if (rf_we) begin
				rf_valid_q[rf_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						strobe_q <= 1'b0;
						state_q  <= (action && !halt_q) ? ST_FETCH : ST_DONE;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= (opc == OP_LDR) ? ST_LOAD : ST_DONE;
					pc_q    <= pc_q + 1'b1;
					unique case (opc)
						OP_ALU: begin
							if (f_fn == ALU_ADD) begin
								carry_q <= alu_res.carry;
							end
						end
						OP_CMP: begin
							cmp_q <= alu_res.cmp;
						end
						OP_JMP: begin
							if (stop) begin
								halt_q <= 1'b1;
								pc_q   <= pc_q;
							end else if (take) begin
								pc_q <= vb[PC_W-1:0];
							end
						end
						OP_LDD, OP_LDR, OP_LDI, OP_STD, OP_STR, OP_MOV: ;
						OP_OUT: begin
							strobe_q <= 1'b1;
							if (instr_q[7]) begin
								psel_q <= instr_q[11:9];
							end else if (instr_q[8]) begin
								portb_q <= va;
							end else begin
								porta_q <= va;
							end
						end
						default: begin
							// nop and unused opcodes halt in place
							halt_q <= 1'b1;
							pc_q   <= pc_q;
						end
					endcase
				end
				ST_LOAD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			pc_out_q     <= pc_q;
			halt_out_q   <= halt_q;
			strobe_out_q <= strobe_q;
			porta_out_q  <= porta_q;
			portb_out_q  <= portb_q;
			psel_out_q   <= psel_q;
			carry_out_q  <= carry_q;
			cmp_out_q    <= cmp_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pc           = pc_out_q;
	assign halted       = halt_out_q;
	assign port_strobe  = strobe_out_q;
	assign port_data_a  = porta_out_q;
	assign port_data_b  = portb_out_q;
	assign port_select  = psel_out_q;
	assign carry_flag   = carry_out_q;
	assign compare_flag = cmp_out_q;

endmodule

FILE: rtl/c32is_checker.sv
// ----------------------------------------------------------------------------
// c32is_checker
// port-level checks of the instruction step core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cpu32_instruction_step_macros.svh"

module c32is_checker import c32is_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input logic [PC_W-1:0] pc,
	input logic            halted,
	input logic            port_strobe
);

	`C32IS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")
	`C32IS_ASSERT_NOW(a_halt_no_strobe, out_valid && halted, !port_strobe, "strobe on halted beat")
	`C32IS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out beat dropped")
	`C32IS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(pc) && $stable(halted), "stalled beat changed")

endmodule

bind cpu32_instruction_step c32is_checker u_c32is_checker (.*);

FILE: verif/cpu32_instruction_step_tb.sv
// ----------------------------------------------------------------------------
// cpu32_instruction_step_tb
// self-checking bench: small programs are written into the word memory and
// stepped one instruction at a time; every result beat is compared against
// an in-bench instruction-set predictor, under varying idle and stall load
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu32_instruction_step_tb;
	import c32is_pkg::*;

	localparam int CLK_HALF   = 4;
	localparam int RAND_BEATS = 850;
	localparam int MEM_WORDS  = MEM_DEPTH_DEF;

	// one result beat as seen on the output ports
	typedef struct packed {
		logic [PC_W-1:0] pc;
		logic            halted;
		logic            strobe;
		logic [XLEN-1:0] pa;
		logic [XLEN-1:0] pb;
		logic [2:0]      sel;
		logic            carry;
		logic            cmp;
	} step_res_t;

	// one row of the directed program table
	typedef struct {
		logic        action;
		logic [15:0] address;
		logic [31:0] data;
		bit          typed;
		step_res_t   res;
	} row_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	logic            action;
	logic [15:0]     address;
	logic [XLEN-1:0] data;
	logic            out_valid;
	logic            out_stall;
	logic [PC_W-1:0] pc;
	logic            halted;
	logic            port_strobe;
	logic [XLEN-1:0] port_data_a;
	logic [XLEN-1:0] port_data_b;
	logic [2:0]      port_select;
	logic            carry_flag;
	logic            compare_flag;

	cpu32_instruction_step uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .address(address), .data(data),
		.out_valid(out_valid), .out_stall(out_stall),
		.pc(pc), .halted(halted), .port_strobe(port_strobe),
		.port_data_a(port_data_a), .port_data_b(port_data_b),
		.port_select(port_select), .carry_flag(carry_flag),
		.compare_flag(compare_flag)
	);

	// shadow architectural state, advanced on every accepted beat
	logic [XLEN-1:0] gpr [NREG];
	logic [PC_W-1:0] cur_pc;
	logic [XLEN-1:0] word_mem [int];
	int              written_addrs [$];
	logic            carry_bit, cmp_bit, halt_bit;
	logic [XLEN-1:0] port_a, port_b;
	logic [2:0]      port_sel;

	step_res_t pending_steps [$];
	row_t      program_rows [$];

	int  err_cnt, checked_cnt, write_cnt, exec_cnt, strobe_cnt;
	int  sender_idle_pct, stall_pct;
	bit  hold_req;
	bit  hold_done;
	int  hold_left;

	// clock and reset
	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	initial begin
		#4ms;
		$display("timeout waiting for result beats");
		$display("Test completed with failures");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	function automatic logic [31:0] mem_rd(input logic [23:0] a);
		if (a >= MEM_WORDS || !word_mem.exists(int'(a)))
			return '0;
		return word_mem[int'(a)];
	endfunction

	function automatic void mem_wr(input logic [23:0] a, input logic [31:0] v);
		if (a < MEM_WORDS) begin
			if (!word_mem.exists(int'(a)))
				written_addrs.push_back(int'(a));
			word_mem[int'(a)] = v;
		end
	endfunction

	function automatic logic [31:0] alu_out(input logic [3:0] fn, input logic [31:0] a,
			input logic [31:0] b, input logic [3:0] n);
		logic [32:0] wide;
		case (fn)
			ALU_ADD: begin
				wide = {1'b0, a} + {1'b0, b};
				carry_bit = wide[32];
				return wide[31:0];
			end
			ALU_SUB:  return a - b;
			ALU_MUL:  return a * b;
			ALU_NEG:  return -a;
			ALU_AND:  return a & b;
			ALU_OR:   return a | b;
			ALU_NOT:  return ~a;
			ALU_NAND: return ~(a & b);
			ALU_XOR:  return a ^ b;
			ALU_XNOR: return ~(a ^ b);
			ALU_SHL:  return a << n;
			ALU_SHR:  return a >> n;
			ALU_SRA:  return $unsigned($signed(a) >>> n);
			ALU_ROL:  return (n == 0) ? a : ((a << n) | (a >> (32 - n)));
			default:  return '0;
		endcase
	endfunction

	function automatic logic cmp_out(input logic [3:0] fn, input logic [31:0] a,
			input logic [31:0] b);
		case (fn)
			CMP_GT:  return a > b;
			CMP_EQ:  return a == b;
			CMP_LT:  return a < b;
			CMP_GE:  return a >= b;
			CMP_LE:  return a <= b;
			default: return 1'b0;
		endcase
	endfunction

	// advance the shadow core by one beat and return what the ports should show
	function automatic step_res_t step_core(input logic act, input logic [15:0] addr,
			input logic [31:0] wdata);
		step_res_t r;
		logic [31:0] w;
		logic [3:0]  op, ra, rb, rd, fn;
		logic        take, jumped, stop, strobe;
		strobe = 1'b0;
		if (!act) begin
			mem_wr({8'd0, addr}, wdata);
		end else if (!halt_bit) begin
			w = mem_rd(cur_pc);
			op = w[31:28]; ra = w[27:24]; rb = w[23:20]; rd = w[19:16]; fn = w[15:12];
			jumped = 1'b0;
			stop = 1'b0;
			case (op)
				OP_ALU: gpr[rd] = alu_out(fn, gpr[ra], gpr[rb], rb);
				OP_CMP: cmp_bit = cmp_out(fn, gpr[ra], gpr[rb]);
				OP_JMP: begin
					take = 1'b0;
					case (ra)
						JC_ALWAYS: take = 1'b1;
						JC_CARRY:  take = carry_bit;
						JC_CMP:    take = cmp_bit;
						JC_NCMP:   take = !cmp_bit;
						default:   stop = 1'b1;
					endcase
					if (take) begin
						cur_pc = gpr[rb][23:0];
						jumped = 1'b1;
					end
				end
				OP_LDD: gpr[ra] = mem_rd(w[23:0]);
				OP_LDR: gpr[rd] = mem_rd(gpr[rb][23:0]);
				OP_LDI: gpr[ra] = {8'd0, w[23:0]};
				OP_STD: mem_wr(w[23:0], gpr[ra]);
				OP_STR: mem_wr(gpr[rb][23:0], gpr[ra]);
				OP_MOV: gpr[rd] = gpr[ra];
				OP_OUT: begin
					if (w[7])
						port_sel = w[11:9];
					else if (w[8])
						port_b = gpr[ra];
					else
						port_a = gpr[ra];
					strobe = 1'b1;
				end
				default: stop = 1'b1;
			endcase
			if (stop)
				halt_bit = 1'b1;
			else if (!jumped)
				cur_pc = cur_pc + 1'b1;
		end
		r.pc = cur_pc; r.halted = halt_bit; r.strobe = strobe;
		r.pa = port_a; r.pb = port_b; r.sel = port_sel;
		r.carry = carry_bit; r.cmp = cmp_bit;
		return r;
	endfunction

	function automatic logic [31:0] enc(input logic [3:0] op, input logic [3:0] a,
			input logic [3:0] b, input logic [3:0] d, input logic [3:0] f, input logic [11:0] lo);
		return {op, a, b, d, f, lo};
	endfunction

	// offer one beat, hold it until accepted, then book its expected result
	task automatic send(input logic act, input logic [15:0] addr, input logic [31:0] wdata,
			input bit typed, input step_res_t typed_res);
		step_res_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		address  <= addr;
		data     <= wdata;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		r = step_core(act, addr, wdata);
		pending_steps.push_back(typed ? typed_res : r);
		if (act)
			exec_cnt++;
		else
			write_cnt++;
	endtask

	// write one instruction at the current pc and execute it
	task automatic run_instr(input logic [31:0] w);
		send(1'b0, cur_pc[15:0], w, 1'b0, '0);
		send(1'b1, 16'($urandom), $urandom, 1'b0, '0);
	endtask

	// pick a register whose low 24 bits point into a written word or past the memory
	function automatic int safe_ptr_reg();
		int r;
		repeat (8) begin
			r = $urandom_range(0, NREG - 1);
			if (gpr[r][23:0] >= MEM_WORDS || word_mem.exists(int'(gpr[r][23:0])))
				return r;
		end
		return -1;
	endfunction

	// random instruction that keeps the core running and reads only written words or words past the memory
	function automatic logic [31:0] rand_instr();
		logic [3:0] op, a, b;
		int r, k;
		op = 4'($urandom_range(OP_ALU, OP_OUT));
		a = 4'($urandom); b = 4'($urandom);
		// steer back to low memory before the pc runs off the end
		if (cur_pc > 60000)
			op = OP_JMP;
		case (op)
			OP_JMP: begin
				r = -1;
				for (int i = 0; i < NREG; i++)
					if (gpr[i][23:0] < 60000 && r < 0 && $urandom_range(0, 3) != 0)
						r = i;
				if (r < 0)
					return {OP_LDI, b, 24'($urandom_range(0, 60000))};
				if (cur_pc > 60000)
					a = JC_ALWAYS;
				else
					a = 4'($urandom_range(JC_ALWAYS, JC_NCMP));
				return enc(OP_JMP, a, 4'(r), 4'($urandom), 4'($urandom), 12'($urandom));
			end
			OP_LDD: begin
				if ($urandom_range(0, 4) == 0)
					return {OP_LDD, a, 24'($urandom_range(MEM_WORDS, 24'hFFFFFF))};
				k = $urandom_range(0, written_addrs.size() - 1);
				return {OP_LDD, a, 24'(written_addrs[k])};
			end
			OP_LDR: begin
				r = safe_ptr_reg();
				if (r < 0) begin
					k = $urandom_range(0, written_addrs.size() - 1);
					return {OP_LDI, b, 24'(written_addrs[k])};
				end
				return enc(OP_LDR, a, 4'(r), 4'($urandom), 4'($urandom), 12'($urandom));
			end
			OP_LDI:
				return {OP_LDI, a, 24'($urandom)};
			OP_STD:
				return {OP_STD, a, ($urandom_range(0, 3) == 0) ? 24'($urandom) :
					24'($urandom_range(0, MEM_WORDS - 1))};
			default:
				return {op, 28'($urandom)};
		endcase
	endfunction

	// receiver: random stall plus a single long hold-off
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		step_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_steps.size() == 0) begin
				$display("result beat with nothing outstanding at %0t", $time);
				err_cnt++;
			end else begin
				e = pending_steps.pop_front();
				checked_cnt++;
				if (port_strobe)
					strobe_cnt++;
				if (pc !== e.pc)                report("pc", 32'(pc), 32'(e.pc));
				if (halted !== e.halted)        report("halted", 32'(halted), 32'(e.halted));
				if (port_strobe !== e.strobe)   report("port_strobe", 32'(port_strobe), 32'(e.strobe));
				if (port_data_a !== e.pa)       report("port_data_a", port_data_a, e.pa);
				if (port_data_b !== e.pb)       report("port_data_b", port_data_b, e.pb);
				if (port_select !== e.sel)      report("port_select", 32'(port_select), 32'(e.sel));
				if (carry_flag !== e.carry)     report("carry_flag", 32'(carry_flag), 32'(e.carry));
				if (compare_flag !== e.cmp)     report("compare_flag", 32'(compare_flag), 32'(e.cmp));
			end
		end
	end

	// add one program row: write the word at pc, then step it
	task automatic add_prog(input logic [3:0] at, input logic [31:0] w, input bit typed,
			input step_res_t res);
		row_t row;
		row = '{1'b0, 16'(at), w, 1'b0, '0};
		program_rows.push_back(row);
		row = '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, typed, res};
		program_rows.push_back(row);
	endtask

	initial begin
		step_res_t none;
		row_t row;
		int n, kind, w;

		arst_n = 1'b0;
		in_valid = 1'b0;
		action = 1'b0;
		address = '0;
		data = '0;
		out_stall = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		sender_idle_pct = 0;
		stall_pct = 0;
		err_cnt = 0; checked_cnt = 0; write_cnt = 0; exec_cnt = 0; strobe_cnt = 0;
		for (int i = 0; i < NREG; i++)
			gpr[i] = '0;
		cur_pc = '0;
		carry_bit = 1'b0; cmp_bit = 1'b0; halt_bit = 1'b0;
		port_a = '0; port_b = '0; port_sel = '0;
		none = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed program: extremes, carry, compare, ports, shift and a taken jump
		add_prog(0, {OP_LDI, 4'd1, 24'hFFFFFF}, 1'b1, '{24'd1, 0, 0, 0, 0, 0, 0, 0});
		add_prog(1, enc(OP_ALU, 4'd0, 4'd0, 4'd3, ALU_NOT, 12'h0), 1'b0, none);
		add_prog(2, enc(OP_ALU, 4'd3, 4'd3, 4'd4, ALU_ADD, 12'h0), 1'b0, none);
		add_prog(3, enc(OP_CMP, 4'd3, 4'd0, 4'd0, CMP_GE, 12'h0), 1'b0, none);
		add_prog(4, enc(OP_OUT, 4'd3, 4'd0, 4'd0, 4'd0, 12'h000), 1'b0, none);
		add_prog(5, enc(OP_OUT, 4'd0, 4'd0, 4'd0, 4'd0, 12'hE80), 1'b1,
			'{24'd6, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0, 3'd7, 1'b1, 1'b1});
		add_prog(6, enc(OP_ALU, 4'd3, 4'd15, 4'd6, ALU_SRA, 12'h0), 1'b0, none);
		add_prog(7, {OP_LDI, 4'd7, 24'h000040}, 1'b0, none);
		add_prog(8, enc(OP_JMP, JC_CARRY, 4'd7, 4'd0, 4'd0, 12'h0), 1'b1,
			'{24'h40, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0, 3'd7, 1'b1, 1'b1});
		// the very first row also reads back the reset state
		program_rows[0].typed = 1'b1;
		program_rows[0].res = '0;
		foreach (program_rows[i]) begin
			row = program_rows[i];
			send(row.action, row.address, row.data, row.typed, row.res);
		end

		// random programs in four load phases
		n = 0;
		while (n < RAND_BEATS) begin
			case ((n * 4) / RAND_BEATS)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 59; stall_pct = 0;  end
				2: begin
					sender_idle_pct = 0; stall_pct = 59;
					// long hold-off so the core backs up onto its input
					if (!hold_done) begin
						hold_req = 1'b1;
						hold_done = 1'b1;
					end
				end
				default: begin sender_idle_pct = 14; stall_pct = 14; end
			endcase
			// mostly well-formed steps, some stray memory writes
			if ($urandom_range(0, 99) < 12) begin
				send(1'b0, 16'($urandom), $urandom, 1'b0, none);
				n++;
			end else begin
				run_instr(rand_instr());
				n += 2;
			end
		end

		// end of program: one way of halting, then random steps and writes while halted
		kind = $urandom_range(0, 3);
		case (kind)
			0: run_instr({OP_NOP, 28'($urandom)});
			1: run_instr(enc(OP_JMP, 4'($urandom_range(4, 15)), 4'($urandom), 4'($urandom),
				4'($urandom), 12'($urandom)));
			2: run_instr({4'($urandom_range(11, 15)), 28'($urandom)});
			default: begin
				// jump past the memory, the fetch there reads zero
				run_instr({OP_LDI, 4'd9, 24'($urandom_range(MEM_WORDS, 24'hFFFFFF))});
				run_instr(enc(OP_JMP, JC_ALWAYS, 4'd9, 4'd0, 4'd0, 12'h0));
				send(1'b1, '0, '0, 1'b0, none);
			end
		endcase
		for (int i = 0; i < 4; i++) begin
			w = $urandom_range(0, 1);
			send(1'(w), 16'($urandom), $urandom, 1'b0, none);
		end
		send(1'b1, '0, '0, 1'b0, none);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_steps.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("covered %0d memory writes and %0d steps, %0d results checked",
			write_cnt, exec_cnt, checked_cnt);
		$display("%0d port writes seen, halted by path %0d, %0d mismatches",
			strobe_cnt, kind, err_cnt);
		if (err_cnt == 0 && pending_steps.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
